### rtl/kfr_pkg.sv
// package for the keyed fifo with requeue
// command, status and cell operation codes; no dependencies
`timescale 1ns / 1ps

package kfr_pkg;

    typedef enum logic [1:0] {
        CMD_ADMIT = 2'd0,
        CMD_PEEK  = 2'd1,
        CMD_SERVE = 2'd2,
        CMD_LEAVE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NOT_PEEKED = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_AT_FRONT   = 3'd5
    } t_status;

    // operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_ADMIT   = 3'd1,
        OP_SERVE   = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_SCAN    = 3'd4,
        OP_REQUEUE = 3'd5
    } t_cell_op;

endpackage

### rtl/kfr_if.sv
// request and response channel interfaces of the keyed fifo
// depends on kfr_pkg
`timescale 1ns / 1ps

interface kfr_req_if #(
    parameter int KEY_BITS = 32
);
    logic                valid;
    logic                ready;
    kfr_pkg::t_cmd       command;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, command, key, input ready);
    modport sink   (input valid, command, key, output ready);
endinterface

interface kfr_rsp_if #(
    parameter int KEY_BITS = 32,
    parameter int CNT_BITS = 5
);
    logic                valid;
    logic                ready;
    kfr_pkg::t_status    status;
    logic [KEY_BITS-1:0] front_key;
    logic [CNT_BITS-1:0] occupancy;

    modport source (output valid, status, front_key, occupancy, input ready);
    modport sink   (input valid, status, front_key, occupancy, output ready);
endinterface

### rtl/kfr_cell.sv
// one queue slot: holds a key, compares it and shifts toward the front
// depends on kfr_pkg
`timescale 1ns / 1ps

module kfr_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = 32,
    parameter int CNT_BITS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kfr_pkg::t_cell_op   i_op,
    input  logic [CNT_BITS-1:0] i_count,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [KEY_BITS-1:0] i_next_key,
    input  logic                i_after,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_after
);
    import kfr_pkg::*;

    localparam logic [CNT_BITS-1:0] IDX      = CNT_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] IDX_NEXT = CNT_BITS'(INDEX + 1);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_after;
    logic                n_after;
    logic                w_hit;
    logic                w_past_hit;

    assign w_hit      = (IDX < i_count) && (r_key == i_key);
    // this slot is at or behind the first match
    assign w_past_hit = r_after || w_hit;
    assign o_after    = w_past_hit;
    assign o_key      = r_key;

    always_comb begin
        n_key   = r_key;
        n_after = r_after;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_ADMIT: begin
                if (IDX == i_count) begin
                    n_key = i_key;
                end
            end
            OP_SERVE: begin
                n_key = i_next_key;
            end
            OP_CLEAR: begin
                n_after = 1'b0;
            end
            OP_SCAN: begin
                n_after = i_after;
            end
            OP_REQUEUE: begin
                // the matched key equals the search key, so the tail takes i_key
                if (w_past_hit) begin
                    if (IDX_NEXT == i_count) begin
                        n_key = i_key;
                    end else if (IDX_NEXT < i_count) begin
                        n_key = i_next_key;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (!i_rst_n) begin
            r_after <= 1'b0;
        end else begin
            r_after <= n_after;
        end
    end

endmodule

### rtl/keyed_fifo_with_requeue.sv
// keyed fifo with requeue: top level, control and the chain of cells
// depends on kfr_pkg, kfr_if and kfr_cell
`timescale 1ns / 1ps

// Usage
//   i_req carries one request (command, key); o_rsp returns exactly one response
//   (status, front_key, occupancy) per request, in order.
//   For admit, peek and serve the response is registered at the
//   accepting edge and is visible on o_rsp the cycle after.
//   Leave is done in steps: every cell compares its key at once,
//   then a "behind the first match" flag travels one cell per cycle down the
//   chain (QUEUE_DEPTH - 1 steps), and a final apply step moves the match to the tail.
//   One request is in work at a time; i_req.ready is high only while no leave
//   is in progress and the response register is empty or being drained.
//   If the receiver stalls, the response holds in its register and the block
//   takes no new request until it is taken.
//   After reset the queue is empty, the peek flag is clear and no response is
//   pending; key storage is not cleared, only slots below the count are read.
//   Serve removes the front only after a peek; every serve clears that flag.
module keyed_fifo_with_requeue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input logic     i_clk,
    input logic     i_rst_n,
    kfr_req_if.sink i_req,
    kfr_rsp_if.source o_rsp
);
    import kfr_pkg::*;

    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int SCAN_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [CNT_BITS-1:0]  CNT_ONE   = CNT_BITS'(1);
    localparam logic [SCAN_BITS-1:0] SCAN_LAST = SCAN_BITS'(QUEUE_DEPTH - 2);
    localparam logic [SCAN_BITS-1:0] SCAN_ONE  = SCAN_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic                 r_armed, n_armed;
    logic [SCAN_BITS-1:0] r_scan, n_scan;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic                 r_out_valid, n_out_valid;
    t_status              r_rsp_status, n_rsp_status;
    logic [KEY_BITS-1:0]  r_rsp_front, n_rsp_front;
    logic [CNT_BITS-1:0]  r_rsp_occ, n_rsp_occ;

    t_cell_op             w_op;
    logic [KEY_BITS-1:0]  w_cell_key;
    logic                 w_accept;
    logic                 w_out_take;
    logic [KEY_BITS-1:0]  w_key [QUEUE_DEPTH];
    logic [KEY_BITS-1:0]  w_next_key [QUEUE_DEPTH];
    logic                 w_after [QUEUE_DEPTH+1];

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_take  = r_out_valid && o_rsp.ready;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_rsp_status;
    assign o_rsp.front_key = r_rsp_front;
    assign o_rsp.occupancy = r_rsp_occ;

    assign w_cell_key = (r_state == S_IDLE) ? i_req.key : r_key;
    assign w_after[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next_key[g] = '0;
        end else begin : g_mid
            assign w_next_key[g] = w_key[g+1];
        end

        kfr_cell #(
            .INDEX    (g),
            .KEY_BITS (KEY_BITS),
            .CNT_BITS (CNT_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (w_op),
            .i_count    (r_count),
            .i_key      (w_cell_key),
            .i_next_key (w_next_key[g]),
            .i_after    (w_after[g]),
            .o_key      (w_key[g]),
            .o_after    (w_after[g+1])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_armed      = r_armed;
        n_scan       = r_scan;
        n_key        = r_key;
        n_out_valid  = r_out_valid && !w_out_take;
        n_rsp_status = r_rsp_status;
        n_rsp_front  = r_rsp_front;
        n_rsp_occ    = r_rsp_occ;
        w_op         = OP_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rsp_status = ST_OK;
                    n_rsp_front  = '0;
                    n_out_valid  = 1'b1;
                    unique case (i_req.command)
                        CMD_ADMIT: begin
                            if (r_count == CNT_FULL) begin
                                n_rsp_status = ST_FULL;
                            end else begin
                                w_op    = OP_ADMIT;
                                n_count = r_count + CNT_ONE;
                            end
                        end
                        CMD_PEEK: begin
                            if (r_count != '0) begin
                                n_rsp_front = w_key[0];
                                n_armed     = 1'b1;
                            end else begin
                                n_rsp_status = ST_EMPTY;
                                n_armed      = 1'b0;
                            end
                        end
                        CMD_SERVE: begin
                            n_armed = 1'b0;
                            if (!r_armed) begin
                                n_rsp_status = ST_NOT_PEEKED;
                            end else if (r_count == '0) begin
                                n_rsp_status = ST_EMPTY;
                            end else begin
                                w_op    = OP_SERVE;
                                n_count = r_count - CNT_ONE;
                            end
                        end
                        CMD_LEAVE: begin
                            // no response until the match flag has crossed the chain
                            n_out_valid = 1'b0;
                            w_op        = OP_CLEAR;
                            n_key       = i_req.key;
                            n_scan      = '0;
                            n_state     = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                    n_rsp_occ = n_count;
                end
            end
            S_SCAN: begin
                w_op = OP_SCAN;
                if (r_scan == SCAN_LAST) begin
                    n_state = S_APPLY;
                end else begin
                    n_scan = r_scan + SCAN_ONE;
                end
            end
            S_APPLY: begin
                n_out_valid = 1'b1;
                n_rsp_front = '0;
                n_rsp_occ   = r_count;
                n_state     = S_IDLE;
                // flag out of the last cell tells whether any slot matched
                if (!w_after[QUEUE_DEPTH]) begin
                    n_rsp_status = ST_NOT_FOUND;
                end else if (w_after[1]) begin
                    n_rsp_status = ST_AT_FRONT;
                end else begin
                    n_rsp_status = ST_OK;
                    w_op         = OP_REQUEUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_scan       <= n_scan;
        r_rsp_status <= n_rsp_status;
        r_rsp_front  <= n_rsp_front;
        r_rsp_occ    <= n_rsp_occ;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    a_armed_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_count != '0))
        else $error("peek flag armed on an empty queue");

    a_serve_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.command == CMD_SERVE) && r_armed && (r_count != '0))
        |=> (r_count == $past(r_count) - CNT_ONE))
        else $error("serve did not remove one entry");

    a_leave_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |=> (r_out_valid && (r_rsp_occ == $past(r_count))
        && (r_count == $past(r_count))))
        else $error("leave changed occupancy or lost its response");

endmodule

### tb/tb.sv
// self-checking testbench for the keyed fifo with requeue
// depends on kfr_pkg, kfr_if and keyed_fifo_with_requeue from the rtl folder
`timescale 1ns / 1ps

module tb;
    import kfr_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_BITS    = 32;
    localparam int CNT_BITS    = 5;
    localparam int RANDOM_REQS = 1000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 12;

    typedef struct packed {
        t_cmd                command;
        logic [KEY_BITS-1:0] key;
    } t_queue_req;

    typedef struct packed {
        t_status             status;
        logic [KEY_BITS-1:0] front_key;
        logic [CNT_BITS-1:0] occupancy;
    } t_queue_rsp;

    logic i_clk;
    logic i_rst_n;

    kfr_req_if #(.KEY_BITS(KEY_BITS)) req_ch ();
    kfr_rsp_if #(.KEY_BITS(KEY_BITS), .CNT_BITS(CNT_BITS)) rsp_ch ();

    keyed_fifo_with_requeue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .KEY_BITS   (KEY_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // requests waiting to be driven and responses waiting to arrive
    t_queue_req          pending_reqs[$];
    t_queue_rsp          awaited_rsps[$];
    int                  total_reqs;
    int                  accepted_reqs;
    int                  errors;
    int                  cycles;

    // shadow of the queue contents, front first
    logic [KEY_BITS-1:0] shadow_keys[$];
    bit                  shadow_armed;

    int                  cmd_seen[4];
    int                  status_seen[8];
    int                  peak_occupancy;

    logic [KEY_BITS-1:0] key_pool[POOL_SIZE];

    // starts low so the first rising edge comes after the initial setup
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, awaited_rsps.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_queue_rsp apply_request(t_queue_req rq);
        t_queue_rsp rsp;
        int         hit;
        rsp.status    = ST_OK;
        rsp.front_key = '0;
        case (rq.command)
            CMD_ADMIT: begin
                if (shadow_keys.size() >= QUEUE_DEPTH)
                    rsp.status = ST_FULL;
                else
                    shadow_keys.push_back(rq.key);
            end
            CMD_PEEK: begin
                if (shadow_keys.size() > 0) begin
                    rsp.front_key = shadow_keys[0];
                    shadow_armed  = 1'b1;
                end else begin
                    rsp.status   = ST_EMPTY;
                    shadow_armed = 1'b0;
                end
            end
            CMD_SERVE: begin
                if (!shadow_armed)
                    rsp.status = ST_NOT_PEEKED;
                else if (shadow_keys.size() == 0)
                    rsp.status = ST_EMPTY;
                else
                    void'(shadow_keys.pop_front());
                shadow_armed = 1'b0;
            end
            default: begin
                hit = -1;
                foreach (shadow_keys[i]) begin
                    if (hit < 0 && shadow_keys[i] == rq.key)
                        hit = i;
                end
                if (hit < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else if (hit == 0) begin
                    rsp.status = ST_AT_FRONT;
                end else begin
                    // first match goes to the tail, a match already there stays
                    shadow_keys.delete(hit);
                    shadow_keys.push_back(rq.key);
                end
            end
        endcase
        rsp.occupancy = CNT_BITS'(shadow_keys.size());
        return rsp;
    endfunction

    function automatic int draw_wait(ref int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // request driver
    int req_gap;
    int req_burst;
    always @(posedge i_clk) begin
        t_queue_req next_req;
        t_queue_rsp exp_rsp;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_gap      <= $urandom_range(0, 3);
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                exp_rsp = apply_request('{req_ch.command, req_ch.key});
                awaited_rsps.push_back(exp_rsp);
                accepted_reqs++;
                cmd_seen[req_ch.command]++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap > 0) begin
                    req_gap      <= req_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    next_req       = pending_reqs.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.command <= next_req.command;
                    req_ch.key     <= next_req.key;
                    req_gap        <= draw_wait(req_burst);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and checker
    int rsp_stall;
    int rsp_burst;
    always @(posedge i_clk) begin
        t_queue_rsp got;
        t_queue_rsp exp_rsp;
        int         stall_next;
        stall_next = rsp_stall;
        if (!i_rst_n) begin
            stall_next = 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.status, rsp_ch.front_key, rsp_ch.occupancy};
            if (awaited_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected response status %0d front %h occupancy %0d",
                         $time, got.status, got.front_key, got.occupancy);
            end else begin
                exp_rsp = awaited_rsps.pop_front();
                if (got !== exp_rsp) begin
                    errors++;
                    $display("%0t: response mismatch: expected status %0d front %h occ %0d",
                             $time, exp_rsp.status, exp_rsp.front_key, exp_rsp.occupancy);
                    $display("%0t:                    actual   status %0d front %h occ %0d",
                             $time, got.status, got.front_key, got.occupancy);
                end
                status_seen[exp_rsp.status]++;
                if (exp_rsp.occupancy > peak_occupancy)
                    peak_occupancy = exp_rsp.occupancy;
            end
            stall_next = draw_wait(rsp_burst);
        end else if (rsp_ch.valid && rsp_stall > 0) begin
            stall_next = rsp_stall - 1;
        end
        rsp_stall    <= stall_next;
        rsp_ch.ready <= (stall_next == 0);
    end

    task automatic add_req(t_cmd command, logic [KEY_BITS-1:0] key);
        pending_reqs.push_back('{command, key});
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key(int fresh_pct);
        if ($urandom_range(0, 99) < fresh_pct)
            return $urandom();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial begin
        bit filling;
        int roll;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_ADMIT;
        req_ch.key     = '0;
        rsp_ch.ready   = 1'b0;
        cycles         = 0;
        errors         = 0;
        accepted_reqs  = 0;
        peak_occupancy = 0;
        req_burst      = 0;
        rsp_burst      = 0;
        rsp_stall      = 0;
        shadow_armed   = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        // directed: empty queue cases, key extremes, duplicates and every leave outcome
        add_req(CMD_PEEK,  32'h1234_5678);
        add_req(CMD_SERVE, '0);
        add_req(CMD_LEAVE, 32'h0000_0005);
        add_req(CMD_ADMIT, '0);
        add_req(CMD_ADMIT, '1);
        add_req(CMD_ADMIT, '0);
        add_req(CMD_ADMIT, 32'hA5A5_A5A5);
        add_req(CMD_LEAVE, '1);
        add_req(CMD_LEAVE, '0);
        add_req(CMD_LEAVE, '1);
        add_req(CMD_LEAVE, 32'h5A5A_5A5A);
        add_req(CMD_PEEK,  '1);
        add_req(CMD_LEAVE, 32'hA5A5_A5A5);
        add_req(CMD_ADMIT, 32'h5A5A_5A5A);
        add_req(CMD_SERVE, 32'hFFFF_0000);
        add_req(CMD_SERVE, '0);
        add_req(CMD_PEEK,  '0);
        add_req(CMD_SERVE, '0);
        add_req(CMD_LEAVE, 32'h8000_0001);
        add_req(CMD_PEEK,  '0);
        add_req(CMD_SERVE, '0);
        add_req(CMD_PEEK,  '0);
        add_req(CMD_SERVE, '0);

        // random: alternating fill and drain phases so both full and empty recur
        filling = 1'b1;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 60 == 0)
                filling = !filling || (n == 0);
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 50 : 15)) begin
                add_req(CMD_ADMIT, pick_key(30));
            end else if (roll < (filling ? 75 : 35)) begin
                add_req(CMD_LEAVE, pick_key(10));
            end else if (roll < 90) begin
                // peek then serve is the normal way to take the front
                add_req(CMD_PEEK, $urandom());
                add_req(CMD_SERVE, $urandom());
                n++;
            end else begin
                add_req(t_cmd'($urandom_range(0, 3)), $urandom());
            end
        end
        total_reqs = pending_reqs.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_reqs < total_reqs || awaited_rsps.size() > 0)
            @(negedge i_clk);
        // a late or extra response would show up within a leave time
        repeat (2 * QUEUE_DEPTH + 4) @(negedge i_clk);

        $display("%0d requests: admit %0d, peek %0d, serve %0d, leave %0d; peak occupancy %0d",
                 accepted_reqs, cmd_seen[CMD_ADMIT], cmd_seen[CMD_PEEK],
                 cmd_seen[CMD_SERVE], cmd_seen[CMD_LEAVE], peak_occupancy);
        $display("outcomes: ok %0d, full %0d, empty %0d, not peeked %0d, %s %0d, front %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOT_PEEKED], "not found", status_seen[ST_NOT_FOUND],
                 status_seen[ST_AT_FRONT]);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
